[rtl/txc_pkg.sv]
// ----------------------------------------------------------------------------
// txc_pkg
// Shared types and constants of the text console cell engine: item kinds,
// control characters, cell codes, register map and sequencer states.
// ----------------------------------------------------------------------------
package txc_pkg;

  localparam int MAX_COLS_DEF = 80;
  localparam int MAX_ROWS_DEF = 25;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [2:0] REG_COLS    = 3'd0;
  localparam logic [2:0] REG_ROWS    = 3'd1;
  localparam logic [2:0] REG_FG      = 3'd2;
  localparam logic [2:0] REG_BG      = 3'd3;
  localparam logic [2:0] REG_INVERSE = 3'd4;
  localparam logic [2:0] REG_BOLD    = 3'd5;

  localparam logic [6:0] COLS_RST = 7'd80;
  localparam logic [4:0] ROWS_RST = 5'd25;
  localparam logic [3:0] FG_RST   = 4'd7;
  localparam logic [3:0] BG_RST   = 4'd0;

  localparam logic [7:0]  CHAR_LF    = 8'h0a;
  localparam logic [7:0]  CHAR_CR    = 8'h0d;
  localparam logic [7:0]  CHAR_BS    = 8'h08;
  localparam logic [7:0]  BLANK_CHAR = 8'h20;
  localparam logic [7:0]  BOLD_BIT   = 8'h08;
  localparam logic [15:0] RESET_CELL = 16'h0720;

  typedef enum logic [2:0] {
    KIND_PUT_CUR = 3'd0,
    KIND_PUT_POS = 3'd1,
    KIND_MOVE    = 3'd2,
    KIND_CLEAR   = 3'd3,
    KIND_READ    = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_LIMIT,
    S_COPY,
    S_FILL,
    S_WR,
    S_RD,
    S_RDW,
    S_RESP
  } state_t;

endpackage

[rtl/text_console_cell_engine.sv]
// ----------------------------------------------------------------------------
// text_console_cell_engine
// Text-mode screen store of character/attribute cells with a cursor, driven
// by a small sequencer around one shared multiply-add address unit.
// ----------------------------------------------------------------------------
// Sequence: an accepted item passes S_EXEC then S_RESP for cursor moves and
//   controls; a cell write adds S_WR (and a second S_EXEC when the column wraps),
//   a cell read adds S_RD and S_RDW before S_RESP.
// Flow: one transaction at a time; the next is taken the cycle after the result
//   is loaded. Scroll and clear walk the cells in use; a character may scroll several times when rows have shrunk.
// Reset: synchronous; a clearing pass fills all MAX_COLS*MAX_ROWS cells of the
//   store with blanks (attribute 0x07) before the first item is taken.
// ----------------------------------------------------------------------------
module text_console_cell_engine #(
  parameter int MAX_COLS = txc_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = txc_pkg::MAX_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_kind,
  input  logic [7:0]                    in_char_code,
  input  logic [6:0]                    in_column,
  input  logic [4:0]                    in_line,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_cell_char,
  output logic [7:0]                    out_cell_attr,
  output logic [6:0]                    out_cursor_col,
  output logic [4:0]                    out_cursor_row,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [txc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [txc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [txc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready
);

  localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
  localparam int AW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int PW    = $clog2(CELL_COUNT + 1);
  localparam int COL_W = $clog2(MAX_COLS + 1);
  localparam int ROW_W = $clog2(MAX_ROWS + 2);
  localparam int HGT_W = $clog2(MAX_ROWS + 1);
  localparam int CCW   = (COL_W > 7) ? COL_W : 7;
  localparam int RCW   = (ROW_W > 5) ? ROW_W : 5;

  // configuration registers
  logic [6:0] cols_cfg_r;
  logic [4:0] rows_cfg_r;
  logic [3:0] fg_r;
  logic [3:0] bg_r;
  logic       inverse_r;
  logic       bold_r;
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= txc_pkg::COLS_RST;
      rows_cfg_r <= txc_pkg::ROWS_RST;
      fg_r       <= txc_pkg::FG_RST;
      bg_r       <= txc_pkg::BG_RST;
      inverse_r  <= 1'b0;
      bold_r     <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        txc_pkg::REG_COLS:    cols_cfg_r <= pwdata[6:0];
        txc_pkg::REG_ROWS:    rows_cfg_r <= pwdata[4:0];
        txc_pkg::REG_FG:      fg_r       <= pwdata[3:0];
        txc_pkg::REG_BG:      bg_r       <= pwdata[3:0];
        txc_pkg::REG_INVERSE: inverse_r  <= pwdata[0];
        txc_pkg::REG_BOLD:    bold_r     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      txc_pkg::REG_COLS:    prdata = txc_pkg::CFG_DATA_W'(cols_cfg_r);
      txc_pkg::REG_ROWS:    prdata = txc_pkg::CFG_DATA_W'(rows_cfg_r);
      txc_pkg::REG_FG:      prdata = txc_pkg::CFG_DATA_W'(fg_r);
      txc_pkg::REG_BG:      prdata = txc_pkg::CFG_DATA_W'(bg_r);
      txc_pkg::REG_INVERSE: prdata = txc_pkg::CFG_DATA_W'(inverse_r);
      txc_pkg::REG_BOLD:    prdata = txc_pkg::CFG_DATA_W'(bold_r);
      default:              prdata = '0;
    endcase
  end

  // saturated screen size and attribute byte
  logic [COL_W-1:0] eff_cols;
  logic [HGT_W-1:0] eff_rows;
  logic [7:0]       attr;

  always_comb begin
    if (cols_cfg_r == 7'd0) begin
      eff_cols = COL_W'(1);
    end else if (CCW'(cols_cfg_r) > CCW'(MAX_COLS)) begin
      eff_cols = COL_W'(MAX_COLS);
    end else begin
      eff_cols = COL_W'(cols_cfg_r);
    end
    if (rows_cfg_r == 5'd0) begin
      eff_rows = HGT_W'(1);
    end else if (RCW'(rows_cfg_r) > RCW'(MAX_ROWS)) begin
      eff_rows = HGT_W'(MAX_ROWS);
    end else begin
      eff_rows = HGT_W'(rows_cfg_r);
    end
    attr = inverse_r ? {fg_r, bg_r} : {bg_r, fg_r};
    if (bold_r) begin
      attr = attr | txc_pkg::BOLD_BIT;
    end
  end

  // sequencer state
  txc_pkg::state_t  state_r, state_nxt;
  logic [PW-1:0]    ptr_r, ptr_nxt;
  logic [PW-1:0]    mac_r, mac_nxt;
  logic             cp_pend_r, cp_pend_nxt;
  logic [AW-1:0]    cp_addr_r, cp_addr_nxt;
  logic             lf_scr_r, lf_scr_nxt;
  logic [COL_W-1:0] cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0] cur_row_r, cur_row_nxt;
  logic [COL_W-1:0] w_r, w_nxt;
  logic [HGT_W-1:0] h_r, h_nxt;
  logic [2:0]       kind_r, kind_nxt;
  logic [7:0]       ch_r, ch_nxt;
  logic [6:0]       x_r, x_nxt;
  logic [4:0]       y_r, y_nxt;
  logic [7:0]       res_char_r, res_char_nxt;
  logic [7:0]       res_attr_r, res_attr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_char_r, out_char_nxt;
  logic [7:0]       out_attr_r, out_attr_nxt;
  logic [6:0]       out_col_r, out_col_nxt;
  logic [4:0]       out_row_r, out_row_nxt;

  // cell store ports
  logic [15:0]      mem [CELL_COUNT];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [15:0]      mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [15:0]      rd_q_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q_r <= mem[mem_raddr];
  end

  // shared multiply-add unit: row * columns + column
  logic [PW-1:0] mac_a;
  logic [PW-1:0] mac_b;
  logic [PW-1:0] mac_res;

  always_comb begin
    if (state_r == txc_pkg::S_LIMIT) begin
      mac_a = PW'(h_r) - PW'(1);
      mac_b = '0;
    end else if (kind_r == txc_pkg::KIND_PUT_CUR) begin
      mac_a = PW'(cur_row_r);
      mac_b = PW'(cur_col_r);
    end else begin
      mac_a = PW'(y_r);
      mac_b = PW'(x_r);
    end
  end

  assign mac_res = mac_a * PW'(w_r) + mac_b;

  logic          row_ge_h;
  logic          col_ge_w;
  logic          x_in;
  logic          y_in;
  logic [PW-1:0] ptr_inc;
  logic [PW-1:0] fill_end;
  logic [PW-1:0] copy_src;

  assign row_ge_h = cur_row_r >= ROW_W'(h_r);
  assign col_ge_w = cur_col_r >= w_r;
  assign x_in     = CCW'(x_r) < CCW'(w_r);
  assign y_in     = RCW'(y_r) < RCW'(h_r);
  assign ptr_inc  = ptr_r + PW'(1);
  assign fill_end = mac_r + PW'(w_r);
  assign copy_src = ptr_r + PW'(w_r);

  always_comb begin
    state_nxt    = state_r;
    ptr_nxt      = ptr_r;
    mac_nxt      = mac_r;
    cp_pend_nxt  = 1'b0;
    cp_addr_nxt  = cp_addr_r;
    lf_scr_nxt   = lf_scr_r;
    cur_col_nxt  = cur_col_r;
    cur_row_nxt  = cur_row_r;
    w_nxt        = w_r;
    h_nxt        = h_r;
    kind_nxt     = kind_r;
    ch_nxt       = ch_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    res_char_nxt = res_char_r;
    res_attr_nxt = res_attr_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt = out_char_r;
    out_attr_nxt = out_attr_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    mem_we       = 1'b0;
    mem_waddr    = ptr_r[AW-1:0];
    mem_wdata    = txc_pkg::RESET_CELL;
    mem_raddr    = mac_r[AW-1:0];

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      txc_pkg::S_INIT: begin
        mem_we = 1'b1;
        if (ptr_r == PW'(CELL_COUNT - 1)) begin
          ptr_nxt   = '0;
          state_nxt = txc_pkg::S_IDLE;
        end else begin
          ptr_nxt = ptr_inc;
        end
      end

      txc_pkg::S_IDLE: begin
        if (in_valid) begin
          kind_nxt     = in_kind;
          ch_nxt       = in_char_code;
          x_nxt        = in_column;
          y_nxt        = in_line;
          w_nxt        = eff_cols;
          h_nxt        = eff_rows;
          lf_scr_nxt   = 1'b0;
          res_char_nxt = '0;
          res_attr_nxt = '0;
          state_nxt    = txc_pkg::S_EXEC;
        end
      end

      txc_pkg::S_EXEC: begin
        case (kind_r)
          txc_pkg::KIND_PUT_CUR: begin
            case (ch_r)
              txc_pkg::CHAR_LF: begin
                if (row_ge_h && !lf_scr_r) begin
                  lf_scr_nxt = 1'b1;
                  state_nxt  = txc_pkg::S_LIMIT;
                end else begin
                  cur_col_nxt = '0;
                  cur_row_nxt = cur_row_r + ROW_W'(1);
                  state_nxt   = txc_pkg::S_RESP;
                end
              end
              txc_pkg::CHAR_CR: begin
                cur_col_nxt = '0;
                state_nxt   = txc_pkg::S_RESP;
              end
              txc_pkg::CHAR_BS: begin
                if (cur_col_r != '0) begin
                  cur_col_nxt = cur_col_r - COL_W'(1);
                end
                state_nxt = txc_pkg::S_RESP;
              end
              default: begin
                if (col_ge_w) begin
                  // wrap to the next row and re-evaluate
                  cur_col_nxt = '0;
                  cur_row_nxt = cur_row_r + ROW_W'(1);
                end else if (row_ge_h) begin
                  state_nxt = txc_pkg::S_LIMIT;
                end else begin
                  mac_nxt     = mac_res;
                  cur_col_nxt = cur_col_r + COL_W'(1);
                  state_nxt   = txc_pkg::S_WR;
                end
              end
            endcase
          end
          txc_pkg::KIND_PUT_POS: begin
            if (x_in && y_in) begin
              cur_col_nxt = COL_W'(x_r);
              cur_row_nxt = ROW_W'(y_r);
              mac_nxt     = mac_res;
              state_nxt   = txc_pkg::S_WR;
            end else begin
              state_nxt = txc_pkg::S_RESP;
            end
          end
          txc_pkg::KIND_MOVE: begin
            cur_col_nxt = (CCW'(x_r) > CCW'(w_r)) ? w_r : COL_W'(x_r);
            cur_row_nxt = (RCW'(y_r) > RCW'(h_r)) ? ROW_W'(h_r) : ROW_W'(y_r);
            state_nxt   = txc_pkg::S_RESP;
          end
          txc_pkg::KIND_CLEAR: begin
            state_nxt = txc_pkg::S_LIMIT;
          end
          txc_pkg::KIND_READ: begin
            if (x_in && y_in) begin
              mac_nxt   = mac_res;
              state_nxt = txc_pkg::S_RD;
            end else begin
              state_nxt = txc_pkg::S_RESP;
            end
          end
          default: begin
            state_nxt = txc_pkg::S_RESP;
          end
        endcase
      end

      txc_pkg::S_LIMIT: begin
        // hold the start of the last row
        mac_nxt = mac_res;
        ptr_nxt = '0;
        state_nxt = (kind_r == txc_pkg::KIND_CLEAR) ? txc_pkg::S_FILL : txc_pkg::S_COPY;
      end

      txc_pkg::S_COPY: begin
        mem_we    = cp_pend_r;
        mem_waddr = cp_addr_r;
        mem_wdata = rd_q_r;
        mem_raddr = copy_src[AW-1:0];
        if (ptr_r < mac_r) begin
          cp_pend_nxt = 1'b1;
          cp_addr_nxt = ptr_r[AW-1:0];
          ptr_nxt     = ptr_inc;
        end else begin
          state_nxt = txc_pkg::S_FILL;
        end
      end

      txc_pkg::S_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = {attr, txc_pkg::BLANK_CHAR};
        if (ptr_inc == fill_end) begin
          if (kind_r == txc_pkg::KIND_CLEAR) begin
            state_nxt = txc_pkg::S_RESP;
          end else begin
            cur_row_nxt = cur_row_r - ROW_W'(1);
            state_nxt   = txc_pkg::S_EXEC;
          end
        end else begin
          ptr_nxt = ptr_inc;
        end
      end

      txc_pkg::S_WR: begin
        mem_we    = 1'b1;
        mem_waddr = mac_r[AW-1:0];
        mem_wdata = {attr, ch_r};
        state_nxt = txc_pkg::S_RESP;
      end

      txc_pkg::S_RD: begin
        state_nxt = txc_pkg::S_RDW;
      end

      txc_pkg::S_RDW: begin
        res_char_nxt = rd_q_r[7:0];
        res_attr_nxt = rd_q_r[15:8];
        state_nxt    = txc_pkg::S_RESP;
      end

      txc_pkg::S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = res_char_r;
          out_attr_nxt  = res_attr_r;
          out_col_nxt   = 7'(cur_col_r);
          out_row_nxt   = 5'(cur_row_r);
          state_nxt     = txc_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = txc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= txc_pkg::S_INIT;
      ptr_r       <= '0;
      cp_pend_r   <= 1'b0;
      lf_scr_r    <= 1'b0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      cp_pend_r   <= cp_pend_nxt;
      lf_scr_r    <= lf_scr_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mac_r      <= mac_nxt;
    cp_addr_r  <= cp_addr_nxt;
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    kind_r     <= kind_nxt;
    ch_r       <= ch_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    res_char_r <= res_char_nxt;
    res_attr_r <= res_attr_nxt;
    out_char_r <= out_char_nxt;
    out_attr_r <= out_attr_nxt;
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
  end

  assign in_stall       = (state_r != txc_pkg::S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_cell_char  = out_char_r;
  assign out_cell_attr  = out_attr_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;

endmodule

[rtl/txc_checker.sv]
// ----------------------------------------------------------------------------
// txc_checker
// Port-level checks of the text console cell engine, bound to the top level.
// ----------------------------------------------------------------------------
module txc_checker #(
  parameter int MAX_COLS = txc_pkg::MAX_COLS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_cell_char,
  input logic [7:0] out_cell_attr,
  input logic [6:0] out_cursor_col,
  input logic [4:0] out_cursor_row
);

  // one transaction in flight: busy straight after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a transaction is in flight");

  // clearing pass follows reset
  a_stall_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input not stalled during the clearing pass");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_cursor_col} <= 8'(MAX_COLS)))
    else $error("reported cursor column beyond the screen");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cell_char)
      && $stable(out_cell_attr) && $stable(out_cursor_col) && $stable(out_cursor_row))
    else $error("stalled result changed");

endmodule

bind text_console_cell_engine txc_checker #(.MAX_COLS(MAX_COLS)) u_txc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_cell_char  (out_cell_char),
  .out_cell_attr  (out_cell_attr),
  .out_cursor_col (out_cursor_col),
  .out_cursor_row (out_cursor_row)
);

[tb/text_console_cell_engine_tb.sv]
// ----------------------------------------------------------------------------
// text_console_cell_engine_tb
// Self-checking bench for the text console cell engine. Each accepted item is
// run through a behavioural mirror of the screen store, cursor and colour
// registers. The expected cursor and cell values are queued, and every result
// transaction is compared field by field with the oldest entry. Directed items
// cover controls, clamping, scrolls, out-of-range positions and the unused
// kinds. Random blocks then cover many screen sizes and colour settings,
// under changing handshake pressure.
// ----------------------------------------------------------------------------
module text_console_cell_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCREEN_COLS = txc_pkg::MAX_COLS_DEF;
  localparam int SCREEN_ROWS = txc_pkg::MAX_ROWS_DEF;
  localparam int CELL_TOTAL  = SCREEN_COLS * SCREEN_ROWS;
  localparam int HOLD_CYCLES = 300;
  localparam int BLOCK_ITEMS = 90;
  localparam int BLOCK_COUNT = 17;
  localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [7:0] glyph;
    logic [7:0] attr;
    logic [6:0] col;
    logic [4:0] row;
  } report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_kind = '0;
  logic [7:0]  in_char_code = '0;
  logic [6:0]  in_column = '0;
  logic [4:0]  in_line = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_cell_char;
  logic [7:0]  out_cell_attr;
  logic [6:0]  out_cursor_col;
  logic [4:0]  out_cursor_row;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [txc_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [txc_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [txc_pkg::CFG_DATA_W-1:0] prdata;
  logic        pready;

  logic [15:0] screen_mirror [CELL_TOTAL];
  int          cur_x;
  int          cur_y;
  logic [6:0]  cols_reg;
  logic [4:0]  rows_reg;
  logic [3:0]  fg_reg;
  logic [3:0]  bg_reg;
  logic        inverse_reg;
  logic        bold_reg;

  report_t     pending_reports [$];
  int          snd_idle = 18;
  int          rcv_idle = 47;
  int          hold_asked = 0;
  int          hold_taken = 0;
  int          hold_left = 0;
  int          errors = 0;
  int          items_sent = 0;
  int          reads_in_range = 0;
  int          scrolls = 0;
  int          settings_used = 0;

  text_console_cell_engine dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_char_code   (in_char_code),
    .in_column      (in_column),
    .in_line        (in_line),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cell_char  (out_cell_char),
    .out_cell_attr  (out_cell_attr),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #100_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int width_now();
    if (cols_reg == 0) return 1;
    if (cols_reg > SCREEN_COLS) return SCREEN_COLS;
    return int'(cols_reg);
  endfunction

  function automatic int height_now();
    if (rows_reg == 0) return 1;
    if (rows_reg > SCREEN_ROWS) return SCREEN_ROWS;
    return int'(rows_reg);
  endfunction

  function automatic logic [7:0] attr_now();
    logic [7:0] a;
    a = inverse_reg ? {fg_reg, bg_reg} : {bg_reg, fg_reg};
    if (bold_reg) a = a | txc_pkg::BOLD_BIT;
    return a;
  endfunction

  function automatic void scroll_screen();
    int w;
    int h;
    int i;
    w = width_now();
    h = height_now();
    for (i = 0; i + w < w * h; i++) screen_mirror[i] = screen_mirror[i + w];
    for (i = (h - 1) * w; i < w * h; i++)
      screen_mirror[i] = {attr_now(), txc_pkg::BLANK_CHAR};
    cur_y = cur_y - 1;
    scrolls++;
  endfunction

  function automatic void write_cell(int x, int y, logic [7:0] ch);
    int idx;
    idx = y * width_now() + x;
    if (idx < CELL_TOTAL) screen_mirror[idx] = {attr_now(), ch};
  endfunction

  function automatic void type_at_cursor(logic [7:0] ch);
    int w;
    int h;
    w = width_now();
    h = height_now();
    if (ch == txc_pkg::CHAR_LF) begin
      if (cur_y >= h) scroll_screen();
      cur_x = 0;
      cur_y = cur_y + 1;
    end else if (ch == txc_pkg::CHAR_CR) begin
      cur_x = 0;
    end else if (ch == txc_pkg::CHAR_BS) begin
      if (cur_x != 0) cur_x = cur_x - 1;
    end else begin
      if (cur_x >= w) begin
        cur_x = 0;
        cur_y = cur_y + 1;
      end
      while (cur_y >= h) scroll_screen();
      write_cell(cur_x, cur_y, ch);
      cur_x = cur_x + 1;
    end
  endfunction

  function automatic report_t apply_item(logic [2:0] k, logic [7:0] ch,
                                         logic [6:0] col, logic [4:0] line);
    int w;
    int h;
    int x;
    int y;
    int i;
    report_t r;
    w = width_now();
    h = height_now();
    x = int'(col);
    y = int'(line);
    r = '0;
    case (k)
      txc_pkg::KIND_PUT_CUR: type_at_cursor(ch);
      txc_pkg::KIND_PUT_POS: begin
        if (x < w && y < h) begin
          cur_x = x;
          cur_y = y;
          write_cell(x, y, ch);
        end
      end
      txc_pkg::KIND_MOVE: begin
        cur_x = (x > w) ? w : x;
        cur_y = (y > h) ? h : y;
      end
      txc_pkg::KIND_CLEAR: begin
        for (i = 0; i < w * h && i < CELL_TOTAL; i++)
          screen_mirror[i] = {attr_now(), txc_pkg::BLANK_CHAR};
      end
      txc_pkg::KIND_READ: begin
        if (x < w && y < h && y * w + x < CELL_TOTAL) begin
          {r.attr, r.glyph} = screen_mirror[y * w + x];
          reads_in_range++;
        end
      end
      default: ;
    endcase
    r.col = cur_x[6:0];
    r.row = cur_y[4:0];
    return r;
  endfunction

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_idle);
    end
  end

  always @(posedge clk) begin : check_reports
    report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        flag_error("result transaction with nothing pending");
      end else begin
        want = pending_reports.pop_front();
        if (out_cell_char !== want.glyph)
          flag_error($sformatf("cell_char expected %0h got %0h", want.glyph, out_cell_char));
        if (out_cell_attr !== want.attr)
          flag_error($sformatf("cell_attr expected %0h got %0h", want.attr, out_cell_attr));
        if (out_cursor_col !== want.col)
          flag_error($sformatf("cursor_col expected %0d got %0d", want.col, out_cursor_col));
        if (out_cursor_row !== want.row)
          flag_error($sformatf("cursor_row expected %0d got %0d", want.row, out_cursor_row));
      end
    end
  end

  task automatic send_item(input logic [2:0] k, input logic [7:0] ch,
                           input logic [6:0] col, input logic [4:0] line);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= k;
    in_char_code <= ch;
    in_column    <= col;
    in_line      <= line;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_reports.push_back(apply_item(k, ch, col, line));
    items_sent++;
  endtask

  task automatic wait_all_reported();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= txc_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      txc_pkg::REG_COLS:    cols_reg = value[6:0];
      txc_pkg::REG_ROWS:    rows_reg = value[4:0];
      txc_pkg::REG_FG:      fg_reg = value[3:0];
      txc_pkg::REG_BG:      bg_reg = value[3:0];
      txc_pkg::REG_INVERSE: inverse_reg = value[0];
      txc_pkg::REG_BOLD:    bold_reg = value[0];
      default: ;
    endcase
  endtask

  task automatic set_screen(input int cols, input int rows, input int fg, input int bg,
                            input int inv, input int bold);
    wait_all_reported();
    repeat (4) @(posedge clk);
    write_reg(txc_pkg::REG_COLS, cols);
    write_reg(txc_pkg::REG_ROWS, rows);
    write_reg(txc_pkg::REG_FG, fg);
    write_reg(txc_pkg::REG_BG, bg);
    write_reg(txc_pkg::REG_INVERSE, inv);
    write_reg(txc_pkg::REG_BOLD, bold);
    settings_used++;
  endtask

  task automatic send_text_line();
    int len;
    int i;
    len = $urandom_range(1, width_now() + 2);
    for (i = 0; i < len; i++)
      send_item(txc_pkg::KIND_PUT_CUR, 8'($urandom_range(32, 126)), 7'($urandom),
                5'($urandom));
    if ($urandom_range(0, 1))
      send_item(txc_pkg::KIND_PUT_CUR, txc_pkg::CHAR_CR, 7'($urandom), 5'($urandom));
    send_item(txc_pkg::KIND_PUT_CUR, txc_pkg::CHAR_LF, 7'($urandom), 5'($urandom));
  endtask

  task automatic run_mixed_items(input int target);
    int pick;
    int w;
    int h;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      w = width_now();
      h = height_now();
      if (pick < 45)
        send_text_line();
      else if (pick < 60)
        send_item(txc_pkg::KIND_READ, 8'($urandom), 7'($urandom_range(0, w - 1)),
                  5'($urandom_range(0, h - 1)));
      else if (pick < 68)
        send_item(txc_pkg::KIND_READ, 8'($urandom), 7'($urandom), 5'($urandom));
      else if (pick < 76)
        send_item(txc_pkg::KIND_PUT_POS, 8'($urandom), 7'($urandom_range(0, w - 1)),
                  5'($urandom_range(0, h - 1)));
      else if (pick < 80)
        send_item(txc_pkg::KIND_PUT_POS, 8'($urandom), 7'($urandom), 5'($urandom));
      else if (pick < 86)
        send_item(txc_pkg::KIND_MOVE, 8'($urandom), 7'($urandom), 5'($urandom));
      else if (pick < 92)
        send_item(txc_pkg::KIND_PUT_CUR, 8'($urandom), 7'($urandom), 5'($urandom));
      else if (pick < 95)
        send_item(txc_pkg::KIND_PUT_CUR, txc_pkg::CHAR_BS, 7'($urandom), 5'($urandom));
      else if (pick < 97)
        send_item(3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)), 8'($urandom),
                  7'($urandom), 5'($urandom));
      else if (pick < 98)
        send_item(txc_pkg::KIND_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom));
      else
        wait_all_reported();
    end
  endtask

  task automatic test_reset_state();
    send_item(txc_pkg::KIND_READ, 8'h00, 7'd0, 5'd0);
    send_item(txc_pkg::KIND_READ, 8'hff, 7'd79, 5'd24);
    send_item(txc_pkg::KIND_READ, 8'h00, 7'd80, 5'd24);
    send_item(txc_pkg::KIND_READ, 8'hff, 7'd127, 5'd31);
  endtask

  task automatic test_cursor_controls();
    send_item(txc_pkg::KIND_PUT_CUR, 8'h41, 7'd127, 5'd31);
    send_item(txc_pkg::KIND_PUT_CUR, txc_pkg::CHAR_BS, 7'd0, 5'd0);
    send_item(txc_pkg::KIND_PUT_CUR, txc_pkg::CHAR_BS, 7'd0, 5'd0);
    send_item(txc_pkg::KIND_PUT_CUR, txc_pkg::CHAR_CR, 7'd0, 5'd0);
    send_item(txc_pkg::KIND_PUT_CUR, txc_pkg::CHAR_LF, 7'd0, 5'd0);
    send_item(txc_pkg::KIND_PUT_CUR, 8'hff, 7'd0, 5'd0);
    send_item(txc_pkg::KIND_PUT_CUR, 8'h00, 7'd0, 5'd0);
    send_item(txc_pkg::KIND_READ, 8'h00, 7'd0, 5'd1);
  endtask

  task automatic test_position_and_move();
    send_item(txc_pkg::KIND_PUT_POS, 8'h5a, 7'd79, 5'd24);
    send_item(txc_pkg::KIND_PUT_POS, 8'h51, 7'd80, 5'd3);
    send_item(txc_pkg::KIND_PUT_POS, 8'h52, 7'd2, 5'd25);
    send_item(txc_pkg::KIND_MOVE, 8'h00, 7'd127, 5'd31);
    send_item(txc_pkg::KIND_PUT_CUR, 8'h78, 7'd0, 5'd0);
    send_item(txc_pkg::KIND_READ, 8'h00, 7'd79, 5'd22);
    send_item(txc_pkg::KIND_PUT_CUR, txc_pkg::CHAR_LF, 7'd0, 5'd0);
    send_item(txc_pkg::KIND_PUT_CUR, txc_pkg::CHAR_LF, 7'd0, 5'd0);
    send_item(KIND_SPARE_FIRST, 8'hff, 7'd127, 5'd31);
    send_item(KIND_SPARE_LAST, 8'h00, 7'd0, 5'd0);
    send_item(txc_pkg::KIND_CLEAR, 8'h00, 7'd0, 5'd0);
  endtask

  task automatic test_backpressure();
    int i;
    int keep_idle;
    wait_all_reported();
    keep_idle = snd_idle;
    snd_idle = 0;
    hold_asked++;
    for (i = 0; i < 40; i++) begin
      if (i % 4 == 3)
        send_item(txc_pkg::KIND_READ, 8'($urandom), 7'($urandom_range(0, 10)),
                  5'($urandom_range(0, 2)));
      else
        send_item(txc_pkg::KIND_PUT_CUR, 8'($urandom_range(32, 126)), 7'($urandom),
                  5'($urandom));
    end
    snd_idle = keep_idle;
    wait_all_reported();
  endtask

  task automatic test_random_traffic();
    int blk;
    for (blk = 0; blk < BLOCK_COUNT; blk++) begin
      if (blk == 6) begin
        snd_idle = 47;
        rcv_idle = 18;
      end
      if (blk == 12) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      case (blk)
        0: set_screen(1, 1, 15, 0, 1, 1);
        1: set_screen(0, 0, 0, 15, 0, 0);
        2: set_screen(127, 31, 9, 6, 1, 0);
        3: set_screen(80, 25, 7, 0, 0, 1);
        default: begin
          if ($urandom_range(0, 5) == 0)
            set_screen($urandom_range(0, 127), $urandom_range(0, 31), $urandom_range(0, 15),
                       $urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 1));
          else
            set_screen($urandom_range(1, 16), $urandom_range(1, 6), $urandom_range(0, 15),
                       $urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 1));
        end
      endcase
      send_item(txc_pkg::KIND_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom));
      run_mixed_items(items_sent + BLOCK_ITEMS);
    end
  endtask

  initial begin : run_tests
    int i;
    for (i = 0; i < CELL_TOTAL; i++) screen_mirror[i] = txc_pkg::RESET_CELL;
    cur_x = 0;
    cur_y = 0;
    cols_reg = txc_pkg::COLS_RST;
    rows_reg = txc_pkg::ROWS_RST;
    fg_reg = txc_pkg::FG_RST;
    bg_reg = txc_pkg::BG_RST;
    inverse_reg = 1'b0;
    bold_reg = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_cursor_controls();
    test_position_and_move();
    test_backpressure();
    test_random_traffic();

    wait_all_reported();
    repeat (20) @(posedge clk);
    $display("Ran %0d console items over %0d screen settings plus the reset one;",
             items_sent, settings_used);
    $display("checked %0d in-range cell reads and %0d predicted scrolls.",
             reads_in_range, scrolls);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
